>>> rtl/core/vsn_pkg.sv
// Package for the vertex set normaliser: widths, status codes, sequencer states.
// No dependencies.
`default_nettype none
package vsn_pkg;
    localparam int COORD_W = 32;
    localparam int NORM_W  = 19;
    localparam int SUM_W   = 38;
    localparam int EXT_W   = 33;
    localparam int MINEXT_W = 31;
    localparam int NUM_W   = 58;
    localparam int DEN_W   = 40;
    localparam int Q_W     = 19;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_DEGEN = 2'd1;
    localparam status_t ST_OVF   = 2'd2;

    typedef enum logic [3:0] {
        S_LOAD, S_EXT, S_DEN, S_READ, S_NUM, S_MUL, S_START, S_DIV, S_NEXT, S_OUT,
        S_DEGEN
    } seq_state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctl_t;
endpackage
`default_nettype wire

>>> rtl/core/vsn_div.sv
// Restoring divider, one quotient bit per cycle, with rounding to nearest.
// Depends on vsn_pkg.
`default_nettype none
module vsn_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [vsn_pkg::NUM_W-1:0]  num,
    input  wire logic [vsn_pkg::DEN_W-1:0]  den,
    output vsn_pkg::div_ctl_t               ctl,
    output logic [vsn_pkg::Q_W-1:0]         quo
);
    import vsn_pkg::*;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] n_reg, n_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [NUM_W:0]   trial;
    logic [NUM_W-1:0] rsum;

    always_comb begin
        rsum      = num + NUM_W'(den >> 1);
        rem_next  = rem_reg;
        n_next    = n_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, n_reg[NUM_W-1]};
        if (start) begin
            rem_next  = '0;
            n_next    = rsum;
            q_next    = '0;
            d_next    = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            n_next = {n_reg[NUM_W-2:0], 1'b0};
            if (trial >= (NUM_W+1)'(d_reg)) begin
                rem_next = NUM_W'(trial - (NUM_W+1)'(d_reg));
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = NUM_W'(trial);
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        n_reg   <= n_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign quo = (q_reg > NUM_W'(131072)) ? Q_W'(131072) : q_reg[Q_W-1:0];
endmodule
`default_nettype wire

>>> rtl/core/vertex_set_normalizer_unit.sv
// Top level of the vertex set normaliser: store, statistics, sequencer.
// Depends on vsn_pkg and vsn_div.
//
//  channel | ports                        | dir
//  s_      | x/y/z_coord, last_vertex     | in,  valid/ready
//  m_      | norm_x/y/z, status, last_res | out, valid/ready
//  cfg     | cfg_we, cfg_data (min_extent)| in,  write only
//
// Loading: one vertex per cycle. On the last vertex: setup (S_EXT, S_DEN), then per
// stored vertex a read state (S_READ) and per axis operand prep (S_NUM, S_MUL,
// S_START), the 58-step serial divider (S_DIV) and S_NEXT, then the output state S_OUT.
// Degenerate set: one result after S_EXT and S_DEN. Synchronous active-low reset; the
// store needs no clearing. Input is not ready while a run is in progress;
// a stalled result simply holds the sequencer.
`default_nettype none
module vertex_set_normalizer_unit #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [30:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic signed [31:0] s_x_coord,
    input  wire logic signed [31:0] s_y_coord,
    input  wire logic signed [31:0] s_z_coord,
    input  wire logic        s_last_vertex,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [18:0] m_norm_x,
    output logic signed [18:0] m_norm_y,
    output logic signed [18:0] m_norm_z,
    output logic [1:0]       m_status,
    output logic             m_last_result
);
    import vsn_pkg::*;
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    logic [COORD_W-1:0] mem_x [MAX_VERTICES];
    logic [COORD_W-1:0] mem_y [MAX_VERTICES];
    logic [COORD_W-1:0] mem_z [MAX_VERTICES];
    logic [3*COORD_W-1:0] rd_reg;

    seq_state_t state_reg, state_next;
    logic [MINEXT_W-1:0] minext_reg;
    logic signed [SUM_W-1:0]   sum_reg  [3];
    logic signed [COORD_W-1:0] min_reg  [3];
    logic signed [COORD_W-1:0] max_reg  [3];
    logic [CNT_W-1:0] cnt_reg;
    logic             ovf_reg;
    logic [EXT_W-1:0] dmax_reg;
    logic             degen_reg;
    logic [DEN_W-1:0] den_reg;
    logic [IDX_W-1:0] k_reg;
    logic [1:0]       ax_reg;
    logic signed [SUM_W+7:0] diff_reg;
    logic             neg_reg;
    logic [NUM_W-1:0] num_reg;
    logic [Q_W-1:0]   q_reg [3];
    logic             ld_acc, div_start, full;
    logic [EXT_W-1:0] ext [3];
    logic             ext_degen;
    logic signed [COORD_W-1:0] p_sel;
    logic [Q_W-1:0]   quo;
    div_ctl_t         dctl;
    logic             out_valid_reg;
    logic             out_last_reg;
    logic [1:0]       out_st_reg;

    assign full   = (cnt_reg == CNT_W'(MAX_VERTICES));
    assign s_ready = (state_reg == S_LOAD);
    assign ld_acc = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (ld_acc && !full) begin
            mem_x[cnt_reg[IDX_W-1:0]] <= s_x_coord;
            mem_y[cnt_reg[IDX_W-1:0]] <= s_y_coord;
            mem_z[cnt_reg[IDX_W-1:0]] <= s_z_coord;
        end
        rd_reg <= {mem_x[k_reg], mem_y[k_reg], mem_z[k_reg]};
    end

    always_comb begin
        for (int a = 0; a < 3; a++)
            ext[a] = EXT_W'($signed({max_reg[a][COORD_W-1], max_reg[a]})
                     - $signed({min_reg[a][COORD_W-1], min_reg[a]}));
    end

    // empty set, all extents zero, or any extent under the threshold
    always_comb begin
        ext_degen = (cnt_reg == '0) || (ext[0] == '0 && ext[1] == '0 && ext[2] == '0);
        for (int a = 0; a < 3; a++)
            if (ext[a] < EXT_W'(minext_reg)) ext_degen = 1'b1;
    end

    always_comb begin
        case (ax_reg)
            2'd0:    p_sel = rd_reg[3*COORD_W-1:2*COORD_W];
            2'd1:    p_sel = rd_reg[2*COORD_W-1:COORD_W];
            default: p_sel = rd_reg[COORD_W-1:0];
        endcase
    end

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        case (state_reg)
            S_LOAD:  if (ld_acc && s_last_vertex) state_next = S_EXT;
            S_EXT:   state_next = S_DEN;
            S_DEN:   state_next = degen_reg ? S_DEGEN : S_READ;
            S_READ:  state_next = S_NUM;
            S_NUM:   state_next = S_MUL;
            S_MUL:   state_next = S_START;
            S_START: begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:   if (!dctl.busy && !dctl.start) state_next = S_NEXT;
            S_NEXT:  state_next = (ax_reg == 2'd2) ? S_OUT : S_NUM;
            S_OUT:   if (out_valid_reg && m_ready)
                         state_next = out_last_reg ? S_LOAD : S_READ;
            S_DEGEN: if (out_valid_reg && m_ready) state_next = S_LOAD;
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_LOAD;
            minext_reg <= MINEXT_W'(66);
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                sum_reg[a] <= '0;
                min_reg[a] <= 32'sh7fffffff;
                max_reg[a] <= 32'sh80000000;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) minext_reg <= cfg_data;
            if (ld_acc) begin
                if (full) ovf_reg <= 1'b1;
                else begin
                    cnt_reg <= cnt_reg + 1'b1;
                    sum_reg[0] <= sum_reg[0] + SUM_W'(s_x_coord);
                    sum_reg[1] <= sum_reg[1] + SUM_W'(s_y_coord);
                    sum_reg[2] <= sum_reg[2] + SUM_W'(s_z_coord);
                    if (s_x_coord < min_reg[0]) min_reg[0] <= s_x_coord;
                    if (s_y_coord < min_reg[1]) min_reg[1] <= s_y_coord;
                    if (s_z_coord < min_reg[2]) min_reg[2] <= s_z_coord;
                    if (s_x_coord > max_reg[0]) max_reg[0] <= s_x_coord;
                    if (s_y_coord > max_reg[1]) max_reg[1] <= s_y_coord;
                    if (s_z_coord > max_reg[2]) max_reg[2] <= s_z_coord;
                end
            end
            if ((state_reg == S_NEXT && ax_reg == 2'd2) || state_reg == S_DEN && degen_reg)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_ready)
                out_valid_reg <= 1'b0;
            if (out_valid_reg && m_ready && out_last_reg) begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
                for (int a = 0; a < 3; a++) begin
                    sum_reg[a] <= '0;
                    min_reg[a] <= 32'sh7fffffff;
                    max_reg[a] <= 32'sh80000000;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_EXT: begin
                degen_reg <= ext_degen;
                if (ext[0] >= ext[1] && ext[0] >= ext[2]) dmax_reg <= ext[0];
                else if (ext[1] >= ext[2]) dmax_reg <= ext[1];
                else dmax_reg <= ext[2];
                k_reg <= '0;
            end
            S_DEN: begin
                if (dmax_reg == '0 || cnt_reg == '0) degen_reg <= 1'b1;
                den_reg <= DEN_W'(dmax_reg) * DEN_W'(cnt_reg);
                ax_reg  <= 2'd0;
            end
            S_READ: ax_reg <= 2'd0;
            S_NUM: diff_reg <= $signed({1'b0, cnt_reg}) * (SUM_W+8)'(p_sel)
                               - (SUM_W+8)'(sum_reg[ax_reg]);
            S_MUL: begin
                neg_reg <= diff_reg[SUM_W+7];
                num_reg <= NUM_W'(diff_reg[SUM_W+7] ? -diff_reg : diff_reg) << 17;
            end
            S_NEXT: begin
                q_reg[ax_reg] <= neg_reg ? Q_W'(-quo) : quo;
                ax_reg <= ax_reg + 1'b1;
            end
            default: ;
        endcase
        if (state_reg == S_NEXT && ax_reg == 2'd2) begin
            out_st_reg   <= ovf_reg ? ST_OVF : ST_OK;
            out_last_reg <= (CNT_W'(k_reg) == cnt_reg - 1'b1);
        end else if (state_reg == S_DEN && degen_reg) begin
            out_st_reg   <= ST_DEGEN;
            out_last_reg <= 1'b1;
            for (int a = 0; a < 3; a++) q_reg[a] <= '0;
        end
        if (state_reg == S_OUT && out_valid_reg && m_ready && !out_last_reg)
            k_reg <= k_reg + 1'b1;
    end

    vsn_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(num_reg), .den(den_reg), .ctl(dctl), .quo(quo)
    );

    assign m_valid       = out_valid_reg;
    assign m_norm_x      = q_reg[0];
    assign m_norm_y      = q_reg[1];
    assign m_norm_z      = q_reg[2];
    assign m_status      = out_st_reg;
    assign m_last_result = out_last_reg;
endmodule
`default_nettype wire

>>> rtl/core/vsn_checker.sv
// Port-level checks for the vertex set normaliser, bound to the top level.
// Depends on vsn_pkg and the vertex_set_normalizer_unit ports.
`default_nettype none
module vsn_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic        m_last_result,
    input wire logic [18:0] m_norm_x
);
    import vsn_pkg::*;

    a_no_load_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input ready while item out");
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_DEGEN || m_status == ST_OVF))
        else $error("bad status");
    a_degen_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_DEGEN |-> m_last_result && m_norm_x == '0)
        else $error("degenerate item malformed");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_last_result))
        else $error("result dropped");
endmodule

bind vertex_set_normalizer_unit vsn_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_last_result(m_last_result), .m_norm_x(m_norm_x)
);
`default_nettype wire

>>> sim/tb_vertex_set_normalizer_unit.sv
// Testbench for vertex_set_normalizer_unit: sends vertex sets, predicts normalised
// output with its own fixed-point model and checks every result item in order.
// Depends on vsn_pkg and the RTL of vertex_set_normalizer_unit.
`timescale 1ns / 100ps
module tb_vertex_set_normalizer_unit;
    import vsn_pkg::*;

    localparam int CAP = 64;

    typedef struct {
        logic [NORM_W-1:0] nx;
        logic [NORM_W-1:0] ny;
        logic [NORM_W-1:0] nz;
        status_t           st;
        logic              last;
    } norm_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [30:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_x_coord = '0;
    logic signed [31:0] s_y_coord = '0;
    logic signed [31:0] s_z_coord = '0;
    logic s_last_vertex = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [18:0] m_norm_x;
    logic signed [18:0] m_norm_y;
    logic signed [18:0] m_norm_z;
    logic [1:0] m_status;
    logic m_last_result;

    norm_item_t expected_norms[$];
    int errors = 0;
    bit send_idle = 1'b0;
    bit recv_idle = 1'b0;
    int hold_cycles = 0;

    // predictor state
    longint vx[CAP];
    longint vy[CAP];
    longint vz[CAP];
    longint sum_a[3];
    longint min_a[3];
    longint max_a[3];
    int vcount;
    bit ovf;
    longint min_ext_reg;

    vertex_set_normalizer_unit #(.MAX_VERTICES(CAP)) uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_x_coord(s_x_coord),
        .s_y_coord(s_y_coord), .s_z_coord(s_z_coord), .s_last_vertex(s_last_vertex),
        .m_valid(m_valid), .m_ready(m_ready), .m_norm_x(m_norm_x),
        .m_norm_y(m_norm_y), .m_norm_z(m_norm_z), .m_status(m_status),
        .m_last_result(m_last_result)
    );

    always #5 aclk = ~aclk;

    function automatic logic [NORM_W-1:0] norm_of(longint p, longint sum, longint n,
                                                 longint den);
        longint num;
        longint mag;
        longint q;
        num = (n * p - sum) * 131072;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        if (q > 131072) q = 131072;
        if (num < 0) q = -q;
        return q[NORM_W-1:0];
    endfunction

    task automatic clear_set();
        for (int a = 0; a < 3; a++) begin
            sum_a[a] = 0;
            min_a[a] = 64'sd2147483647;
            max_a[a] = -64'sd2147483648;
        end
        vcount = 0;
        ovf = 1'b0;
    endtask

    task automatic queue_result(norm_item_t r);
        expected_norms.insert(expected_norms.size(), r);
    endtask

    task automatic predict_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                  logic signed [31:0] z, logic last);
        longint v[3];
        longint e;
        longint dmax;
        longint den;
        bit degen;
        norm_item_t r;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        if (vcount < CAP) begin
            vx[vcount] = v[0];
            vy[vcount] = v[1];
            vz[vcount] = v[2];
            for (int a = 0; a < 3; a++) begin
                sum_a[a] += v[a];
                if (v[a] < min_a[a]) min_a[a] = v[a];
                if (v[a] > max_a[a]) max_a[a] = v[a];
            end
            vcount++;
        end else begin
            ovf = 1'b1;
        end
        if (!last) return;
        degen = (vcount == 0);
        dmax = 0;
        if (!degen) begin
            for (int a = 0; a < 3; a++) begin
                e = max_a[a] - min_a[a];
                if (e < min_ext_reg) degen = 1'b1;
                if (e > dmax) dmax = e;
            end
            if (dmax == 0) degen = 1'b1;
        end
        if (degen) begin
            r.nx = '0; r.ny = '0; r.nz = '0; r.st = ST_DEGEN; r.last = 1'b1;
            queue_result(r);
        end else begin
            den = vcount * dmax;
            for (int k = 0; k < vcount; k++) begin
                r.nx = norm_of(vx[k], sum_a[0], vcount, den);
                r.ny = norm_of(vy[k], sum_a[1], vcount, den);
                r.nz = norm_of(vz[k], sum_a[2], vcount, den);
                r.st = ovf ? ST_OVF : ST_OK;
                r.last = (k == vcount - 1);
                queue_result(r);
            end
        end
        clear_set();
    endtask

    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, logic last);
        int gap;
        if (send_idle && $urandom_range(0, 99) < 36) begin
            s_valid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge aclk);
        end
        s_x_coord = x;
        s_y_coord = y;
        s_z_coord = z;
        s_last_vertex = last;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_vertex(x, y, z, last);
        @(negedge aclk);
    endtask

    task automatic quiesce();
        s_valid = 1'b0;
        while (expected_norms.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    task automatic write_min_extent(logic [30:0] v);
        quiesce();
        cfg_data = v;
        cfg_we = 1'b1;
        @(negedge aclk);
        cfg_we = 1'b0;
        min_ext_reg = v;
    endtask

    function automatic logic signed [31:0] rand_coord(int mode, logic signed [31:0] base);
        case (mode)
            0: return $urandom;
            1: return base + $signed($urandom_range(0, 4000));
            default: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    task automatic send_set(int n, int mode);
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        bx = $urandom;
        by = $urandom;
        bz = $urandom;
        if (bx > 32'sh7fff0000) bx = 32'sh7fff0000;
        if (by > 32'sh7fff0000) by = 32'sh7fff0000;
        if (bz > 32'sh7fff0000) bz = 32'sh7fff0000;
        for (int i = 0; i < n; i++)
            send_vertex(rand_coord(mode, bx), rand_coord(mode, by), rand_coord(mode, bz),
                        i == n - 1);
    endtask

    task automatic test_directed();
        // default threshold: extent 65 degenerate, 66 accepted
        send_vertex(0, 0, 0, 1'b0);
        send_vertex(65, 100, 100, 1'b1);
        send_vertex(0, 0, 0, 1'b0);
        send_vertex(66, 66, 200, 1'b1);
        // single vertex: zero extent
        send_vertex(32'sh12345678, 32'sh0, 32'shdeadbeef, 1'b1);
        // extreme corners
        send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
        send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1);
        send_vertex(32'sh80000000, 32'sh7fffffff, 32'sh0, 1'b0);
        send_vertex(32'sh7fffffff, 32'sh80000000, -32'sd1, 1'b0);
        send_vertex(32'sh0, 32'sh0, 32'sh7fffffff, 1'b1);
        // rounding of inexact quotients
        send_vertex(0, 0, 0, 1'b0);
        send_vertex(3000, 3000, 3000, 1'b0);
        send_vertex(1000, 2000, 500, 1'b1);
    endtask

    task automatic test_overflow();
        // no idling here; store full, extra non-last dropped, last one dropped too
        send_idle = 1'b0;
        recv_idle = 1'b0;
        send_set(CAP + 2, 1);
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    task automatic test_threshold();
        write_min_extent(31'd0);
        send_set(3, 1);
        send_vertex(5, 5, 5, 1'b0);
        send_vertex(5, 5, 6, 1'b1);
        write_min_extent(31'h7fffffff);
        send_set(3, 1);
        send_set(2, 2);
        send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
        send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1);
        write_min_extent(31'($urandom_range(0, 3000)));
        send_set(4, 1);
        write_min_extent(31'd66);
    endtask

    task automatic test_random();
        int sent;
        int n;
        int r;
        sent = 0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        while (sent < 12) begin
            r = $urandom_range(0, 99);
            n = (r < 5) ? $urandom_range(9, 20) : $urandom_range(1, 6);
            send_set(n, (r % 10 < 6) ? 1 : ((r % 10 < 9) ? 0 : 2));
            sent += n;
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 4000;
        send_set(5, 1);
        send_set(4, 0);
        send_set(3, 1);
    endtask

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end else if (recv_idle) begin
            m_ready = ($urandom_range(0, 99) >= 36);
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        norm_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_norms.size() == 0) begin
                $display("%0t: unexpected item x=%h y=%h z=%h st=%0d last=%b", $time,
                         m_norm_x, m_norm_y, m_norm_z, m_status, m_last_result);
                errors++;
            end else begin
                e = expected_norms.pop_front();
                if (m_norm_x !== e.nx) begin
                    $display("%0t: norm_x expected %h actual %h", $time, e.nx, m_norm_x);
                    errors++;
                end
                if (m_norm_y !== e.ny) begin
                    $display("%0t: norm_y expected %h actual %h", $time, e.ny, m_norm_y);
                    errors++;
                end
                if (m_norm_z !== e.nz) begin
                    $display("%0t: norm_z expected %h actual %h", $time, e.nz, m_norm_z);
                    errors++;
                end
                if (m_status !== e.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, m_status);
                    errors++;
                end
                if (m_last_result !== e.last) begin
                    $display("%0t: last_result expected %b actual %b", $time, e.last,
                             m_last_result);
                    errors++;
                end
            end
        end
    end

    initial begin
        #30_000_000;
        $display("vertex_set_normalizer_unit test failed");
        $finish;
    end

    initial begin
        min_ext_reg = 66;
        clear_set();
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        send_idle = 1'b1;
        recv_idle = 1'b1;
        test_directed();
        test_overflow();
        test_threshold();
        test_random();
        recv_idle = 1'b0;
        quiesce();
        test_backpressure();
        quiesce();
        if (errors == 0 && expected_norms.size() == 0) begin
            $display("vertex_set_normalizer_unit test passed");
        end else begin
            $display("vertex_set_normalizer_unit test failed");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/vsn_pkg.sv
rtl/core/vsn_div.sv
rtl/core/vertex_set_normalizer_unit.sv
rtl/core/vsn_checker.sv
sim/tb_vertex_set_normalizer_unit.sv
